FILE: rtl/rtsd_pkg.sv
package rtsd_pkg;

    localparam int SEC_W    = 32;
    localparam int NS_W     = 63;
    localparam int PROD_W   = 62;
    localparam int FRAC_W   = 30;
    localparam int DELTA_W  = 64;
    localparam int CNT_W    = 32;
    localparam int IN_W     = 192;
    localparam int OUT_W    = 384;
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = 6;

    localparam logic [FRAC_W-1:0]  NS_PER_SECOND = 30'd1000000000;
    localparam logic [PROD_W-1:0]  HALF_FRACTION = 62'h80000000;
    localparam logic [DELTA_W-1:0] DELTA_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DELTA_W-1:0] DELTA_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [CNT_W-1:0]   CNT_FULL      = 32'hFFFF_FFFF;

    localparam logic REQ_COMPARE = 1'b0;
    localparam logic REQ_MISS    = 1'b1;

    // operand order for the shared multiplier
    localparam logic [1:0] MUL_SW_SEC  = 2'd0;
    localparam logic [1:0] MUL_SW_FRAC = 2'd1;
    localparam logic [1:0] MUL_HW_SEC  = 2'd2;
    localparam logic [1:0] MUL_HW_FRAC = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_CONV,
        ST_DIFF,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       miss_en;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       conv_en;
        logic       diff_en;
        logic       update_en;
        logic       div_start;
        logic       mean_en;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic is_miss;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/rtsd_div.sv
module rtsd_div
    import rtsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DELTA_W-1:0] dividend,
    input  logic [CNT_W-1:0]   divisor,
    output logic               done,
    output logic [DELTA_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [DELTA_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       trial_sub;
    logic                 fits;

    assign trial     = {rem_reg, quo_reg[DELTA_W-1]};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign trial_sub = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[DELTA_W-1];
            rem_next  = '0;
            quo_next  = dividend[DELTA_W-1] ? (~dividend + 64'd1) : dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // one quotient bit a cycle, restoring
            rem_next = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next = {quo_reg[DELTA_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 64'd1) : quo_reg;

endmodule

FILE: rtl/rtsd_ctrl.sv
module rtsd_ctrl
    import rtsd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [1:0] mul_cnt_reg, mul_cnt_next;

    always_comb begin
        state_next   = state_reg;
        mul_cnt_next = mul_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                mul_cnt_next = MUL_SW_SEC;
                state_next   = sts.is_miss ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == MUL_HW_FRAC) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:      state_next = ST_DIFF;
            ST_DIFF:      state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        cmd.mul_sel = mul_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_START:     cmd.miss_en   = sts.is_miss;
            ST_MUL:       cmd.mul_en    = 1'b1;
            ST_CONV:      cmd.conv_en   = 1'b1;
            ST_DIFF:      cmd.diff_en   = 1'b1;
            ST_UPDATE:    cmd.update_en = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV_WAIT:  cmd.mean_en   = sts.div_done;
            ST_DONE:      cmd.out_load  = sts.out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mul_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            mul_cnt_reg <= mul_cnt_next;
        end
    end

endmodule

FILE: rtl/rtsd_datapath.sv
module rtsd_datapath
    import rtsd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic [0:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    input  cmd_t             cmd,
    output status_t          sts
);

    logic               miss_reg;
    logic [SEC_W-1:0]   op_reg [4];
    logic [SEC_W-1:0]   bracket_in_reg, age_in_reg;
    logic [PROD_W-1:0]  prod_reg [4];
    logic [NS_W-1:0]    sw_ns_reg, hw_ns_reg;
    logic [DELTA_W-1:0] diff_reg;

    logic [CNT_W-1:0]   count_reg, miss_cnt_reg;
    logic [DELTA_W-1:0] sum_reg, last_reg, mean_reg, low_reg, high_reg;
    logic [SEC_W-1:0]   bracket_reg, age_reg;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic [PROD_W-1:0]  sw_round, hw_round;
    logic [DELTA_W-1:0] sum_wrap, sum_sat;
    logic               sum_ovf;
    logic               first;
    logic               div_done;
    logic [DELTA_W-1:0] quotient;

    assign sw_round = prod_reg[MUL_SW_FRAC] + HALF_FRACTION;
    assign hw_round = prod_reg[MUL_HW_FRAC] + HALF_FRACTION;

    assign sum_wrap = sum_reg + diff_reg;
    assign sum_ovf  = (sum_reg[DELTA_W-1] == diff_reg[DELTA_W-1]) &&
                      (sum_wrap[DELTA_W-1] != sum_reg[DELTA_W-1]);
    assign sum_sat  = sum_ovf ? (diff_reg[DELTA_W-1] ? DELTA_MIN : DELTA_MAX) : sum_wrap;
    assign first    = (count_reg == '0);

    rtsd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // capture and conversion datapath
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            miss_reg          <= (s_tuser[0] == REQ_MISS);
            op_reg[MUL_SW_SEC]  <= s_tdata[31:0];
            op_reg[MUL_SW_FRAC] <= s_tdata[63:32];
            op_reg[MUL_HW_SEC]  <= s_tdata[95:64];
            op_reg[MUL_HW_FRAC] <= s_tdata[127:96];
            bracket_in_reg    <= s_tdata[159:128];
            age_in_reg        <= s_tdata[191:160];
        end
        if (cmd.mul_en) begin
            prod_reg[cmd.mul_sel] <= PROD_W'(op_reg[cmd.mul_sel]) * PROD_W'(NS_PER_SECOND);
        end
        if (cmd.conv_en) begin
            // seconds part plus fraction rounded to nearest ns
            sw_ns_reg <= {1'b0, prod_reg[MUL_SW_SEC]} + NS_W'(sw_round[PROD_W-1:32]);
            hw_ns_reg <= {1'b0, prod_reg[MUL_HW_SEC]} + NS_W'(hw_round[PROD_W-1:32]);
        end
        if (cmd.diff_en) begin
            diff_reg <= {1'b0, sw_ns_reg} - {1'b0, hw_ns_reg};
        end
    end

    // statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            miss_cnt_reg <= '0;
            sum_reg      <= '0;
            last_reg     <= '0;
            mean_reg     <= '0;
            low_reg      <= '0;
            high_reg     <= '0;
            bracket_reg  <= '0;
            age_reg      <= '0;
        end else begin
            if (cmd.miss_en && miss_cnt_reg != CNT_FULL) begin
                miss_cnt_reg <= miss_cnt_reg + 32'd1;
            end
            if (cmd.update_en) begin
                if (count_reg != CNT_FULL) begin
                    count_reg <= count_reg + 32'd1;
                end
                sum_reg     <= sum_sat;
                last_reg    <= diff_reg;
                bracket_reg <= bracket_in_reg;
                age_reg     <= age_in_reg;
                if (first || $signed(diff_reg) < $signed(low_reg)) begin
                    low_reg <= diff_reg;
                end
                if (first || $signed(diff_reg) > $signed(high_reg)) begin
                    high_reg <= diff_reg;
                end
            end
            if (cmd.mean_en) begin
                mean_reg <= quotient;
            end
        end
    end

    // output register: hold the item until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_data_reg <= {miss_cnt_reg, age_reg, bracket_reg, high_reg, low_reg,
                             mean_reg, last_reg, count_reg};
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign sts.is_miss  = miss_reg;
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || m_tready;

endmodule

FILE: rtl/rx_timestamp_delta_stats_unit.sv
// Running statistics of the software-minus-hardware receive timestamp difference.
// Each input item carries two 32.32 NTP timestamps (or, with s_tuser set, reports a
// missing hardware timestamp); both are converted to nanoseconds with the fraction
// rounded to nearest, and the signed difference updates a saturating sample count and
// sum, the last value, minimum, maximum and the mean (sum / count, truncated toward
// zero). Every item returns one result with the current statistics. One item is worked
// on at a time: a compare item is converted and folded into the statistics before the
// next item can be accepted, most of the work being the 64-step serial restoring
// divide for the mean; a miss item only advances the miss count. A result that is
// still held by the sink delays the end of the next item until it is taken. The four
// nanosecond products share one 32x30 multiplier.
// A finished result waits in the output register while the next item is accepted.
module rx_timestamp_delta_stats_unit
    import rtsd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // sw_seconds, sw_fraction, hw_seconds, hw_fraction, bracket_ns, age_us
    input  logic [IN_W-1:0]  s_tdata,
    // req_type
    input  logic [0:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // sample_total, delta_last, delta_mean, delta_low, delta_high,
    // bracket_last, age_last, miss_total
    output logic [OUT_W-1:0] m_tdata
);

    cmd_t    cmd;
    status_t sts;

    rtsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rtsd_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

FILE: rtl/rtsd_checker.sv
module rtsd_checker
    import rtsd_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    a_low_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[223:160]) <= $signed(m_tdata[287:224]))
        else $error("minimum above maximum");

    a_no_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31:0] == 32'd0 |->
            m_tdata[95:32] == 64'd0 && m_tdata[159:96] == 64'd0)
        else $error("statistics nonzero before any sample");

endmodule

bind rx_timestamp_delta_stats_unit rtsd_checker u_rtsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
